// ----- rtl/core/dap_pkg.sv -----
// ---------------------------------------------------------------------------
// dap_pkg
// Shared types, constants and the power-of-ten table of the amount parser.
// ---------------------------------------------------------------------------
package dap_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned VALUE_W   = 30;
  localparam int unsigned LIMIT_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_W     = 64;   // 62 payload bits padded to whole bytes

  localparam logic [LIMIT_W-1:0] MAX_DIGITS = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_DIGITS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_DIGITS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTHING  = 2'd1,
    ST_OVER     = 2'd2,
    ST_NONDIGIT = 2'd3
  } status_t;

  // one finished amount, before the fraction is padded
  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   int_value;
    logic [VALUE_W-1:0]   frac_accum;
    logic [LIMIT_W-1:0]   pad_digits;   // number of trailing zeros to append
  } rec_t;

  function automatic logic [VALUE_W-1:0] pow10(input logic [LIMIT_W-1:0] k);
    logic [VALUE_W-1:0] p;
    case (k)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/dap_parser.sv -----
// ---------------------------------------------------------------------------
// dap_parser
// Character-level parse state, limit registers and the finished-amount record.
// ---------------------------------------------------------------------------
module dap_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dap_pkg::CHAR_W-1:0]         s_tdata,    // [7:0] char_code
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dap_pkg::LIMIT_W-1:0]        cfg_data,
  output logic                               rec_valid,
  input  logic                               rec_ready,
  output dap_pkg::rec_t                      rec
);
  import dap_pkg::*;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

  logic [LIMIT_W-1:0] integer_digits;
  logic [LIMIT_W-1:0] fraction_digits;

  logic               in_fraction, in_fraction_next;
  logic [LIMIT_W-1:0] digit_count, digit_count_next;
  logic [VALUE_W-1:0] int_accum, int_accum_next;
  logic [VALUE_W-1:0] frac_accum, frac_accum_next;
  logic               had_int_digits, had_int_digits_next;

  logic               fire;
  logic               is_term, is_digit, is_point;
  logic [LIMIT_W-1:0] ilim, flim;
  logic [3:0]         digit_val;
  logic [VALUE_W-1:0] acc_sel, acc_step;
  logic               emit;
  rec_t               rec_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = !rec_valid || rec_ready;
  assign fire      = s_tvalid && s_tready;

  assign is_term   = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
  assign is_digit  = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
  assign is_point  = (s_tdata == CHAR_POINT);
  assign digit_val = 4'(s_tdata - CHAR_ZERO);

  assign ilim = (integer_digits  > MAX_DIGITS) ? MAX_DIGITS : integer_digits;
  assign flim = (fraction_digits > MAX_DIGITS) ? MAX_DIGITS : fraction_digits;

  // acc * 10 + digit as two shifts and adds
  assign acc_sel  = in_fraction ? frac_accum : int_accum;
  assign acc_step = (acc_sel << 3) + (acc_sel << 1) + VALUE_W'(digit_val);

  always_comb begin
    in_fraction_next    = in_fraction;
    digit_count_next    = digit_count;
    int_accum_next      = int_accum;
    frac_accum_next     = frac_accum;
    had_int_digits_next = had_int_digits;
    emit                = 1'b0;
    rec_next.status     = ST_OK;
    rec_next.int_value  = int_accum;
    rec_next.frac_accum = '0;
    rec_next.pad_digits = '0;

    if (!in_fraction) begin
      if (is_term) begin
        emit = 1'b1;
        if (digit_count == '0) rec_next.status = ST_NOTHING;
      end else if (is_point) begin
        in_fraction_next    = 1'b1;
        had_int_digits_next = (digit_count != '0);
        digit_count_next    = '0;
        frac_accum_next     = '0;
      end else if (digit_count >= ilim) begin
        emit            = 1'b1;
        rec_next.status = ST_OVER;
      end else if (!is_digit) begin
        emit            = 1'b1;
        rec_next.status = ST_NONDIGIT;
      end else begin
        int_accum_next   = acc_step;
        digit_count_next = digit_count + 4'd1;
      end
    end else begin
      if (is_term) begin
        emit = 1'b1;
        if (!had_int_digits && digit_count == '0) begin
          rec_next.status = ST_NOTHING;
        end else begin
          rec_next.frac_accum = frac_accum;
          // a limit lowered mid-amount leaves the fraction unpadded
          if (digit_count < flim) rec_next.pad_digits = flim - digit_count;
        end
      end else if (digit_count >= flim) begin
        emit            = 1'b1;
        rec_next.status = ST_OVER;
      end else if (!is_digit) begin
        emit            = 1'b1;
        rec_next.status = ST_NONDIGIT;
      end else begin
        frac_accum_next  = acc_step;
        digit_count_next = digit_count + 4'd1;
      end
    end

    if (rec_next.status != ST_OK) begin
      rec_next.int_value  = '0;
      rec_next.frac_accum = '0;
      rec_next.pad_digits = '0;
    end

    if (emit) begin
      in_fraction_next    = 1'b0;
      digit_count_next    = '0;
      int_accum_next      = '0;
      frac_accum_next     = '0;
      had_int_digits_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integer_digits  <= MAX_DIGITS;
      fraction_digits <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INTEGER_DIGITS:  integer_digits  <= cfg_data;
        CFG_FRACTION_DIGITS: fraction_digits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_fraction    <= 1'b0;
      digit_count    <= '0;
      int_accum      <= '0;
      frac_accum     <= '0;
      had_int_digits <= 1'b0;
    end else if (fire) begin
      in_fraction    <= in_fraction_next;
      digit_count    <= digit_count_next;
      int_accum      <= int_accum_next;
      frac_accum     <= frac_accum_next;
      had_int_digits <= had_int_digits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (fire && emit) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      rec <= rec_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    digit_count <= MAX_DIGITS)
    else $error("digit count above maximum");

  a_frac_clear_in_int: assert property (@(posedge clk) disable iff (rst)
    !in_fraction |-> (frac_accum == '0))
    else $error("fraction accumulator dirty in integer part");

  a_rec_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec.status != ST_OK) |->
      (rec.int_value == '0 && rec.frac_accum == '0 && rec.pad_digits == '0))
    else $error("error record carries values");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (fire && emit) |=> (digit_count == '0 && !in_fraction && int_accum == '0))
    else $error("parse state not cleared after result");
`endif

endmodule

// ----- rtl/core/dap_scale.sv -----
// ---------------------------------------------------------------------------
// dap_scale
// Pads the fraction with trailing zeros and holds the output register.
// ---------------------------------------------------------------------------
module dap_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rec_valid,
  output logic                         rec_ready,
  input  dap_pkg::rec_t                rec,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dap_pkg::OUT_W-1:0]    m_tdata   // [1:0] status, [31:2] int_value,
                                                 // [61:32] frac_value, [63:62] zero
);
  import dap_pkg::*;

  logic [2*VALUE_W-1:0] product;
  logic [VALUE_W-1:0]   frac_value;
  logic                 load;

  assign product    = rec.frac_accum * pow10(rec.pad_digits);
  assign frac_value = product[VALUE_W-1:0];

  assign rec_ready = !m_tvalid || m_tready;
  assign load      = rec_valid && rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {2'b00, frac_value, rec.int_value, rec.status};
    end
  end

`ifndef SYNTHESIS
  a_out_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[61:2] == '0))
    else $error("error result carries values");

  a_out_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:62] == 2'b00))
    else $error("pad bits set");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !load)
    else $error("output overwritten while stalled");
`endif

endmodule

// ----- rtl/core/decimal_amount_parser_top.sv -----
// ---------------------------------------------------------------------------
// decimal_amount_parser_top
// Streaming decimal amount parser: ASCII characters in, amount results out.
// ---------------------------------------------------------------------------
// Input stream s_*: one character per transaction in s_tdata[7:0].
// Output stream m_*: one result per CR/LF, bad character or character past the digit limit:
//   m_tdata[1:0] status, [31:2] integer part, [61:32] fraction part padded
//   to fraction_digits digits; values are zero unless status is ok.
// Config channel cfg_*: index 0 integer_digits, 1 fraction_digits (4 bits
//   each, above 9 acts as 9); always ready, write only while idle.
// Throughput: one character per cycle while s_tready is high; the
//   multiply-by-ten accumulate feeds the parser state register combinationally.
// Result path: the record register loads at the edge that accepts the
//   character that finishes the amount, and the output register loads from
//   it once the output register is free, raising m_tvalid. The fraction pad
//   multiply sits between those two registers.
// Reset (rst, synchronous): clears parse state and both valid flags, limits
//   go to 9 integer and 2 fraction digits.
// Stall: with m_tready low a finished result waits in the output register,
//   a second one in the record register; characters keep flowing until the
//   record register is also full, then s_tready drops.
// ---------------------------------------------------------------------------
module decimal_amount_parser_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dap_pkg::CHAR_W-1:0]         s_tdata,    // [7:0] char_code
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dap_pkg::OUT_W-1:0]          m_tdata,    // [1:0] status, [31:2] int_value,
                                                         // [61:32] frac_value, [63:62] zero
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dap_pkg::LIMIT_W-1:0]        cfg_data
);
  import dap_pkg::*;

  logic rec_valid;
  logic rec_ready;
  rec_t rec;

  dap_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  dap_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
